/* design/mcdst_pkg.sv */
// Shared types and codes for the mouse click debounce and scroll throttle block.
package mcdst_pkg;

	// Command codes on the input channel
	localparam logic [2:0] CMD_LEFT_DOWN = 3'd0;
	localparam logic [2:0] CMD_WHEEL     = 3'd6;
	localparam logic [2:0] CMD_OTHER     = 3'd7;

	// Result codes
	localparam logic [2:0] EV_LEFT        = 3'd0;
	localparam logic [2:0] EV_MIDDLE      = 3'd1;
	localparam logic [2:0] EV_RIGHT       = 3'd2;
	localparam logic [2:0] EV_SCROLL_UP   = 3'd3;
	localparam logic [2:0] EV_SCROLL_DOWN = 3'd4;

	// Button indexes (command >> 1)
	localparam logic [1:0] BTN_LEFT   = 2'd0;
	localparam logic [1:0] BTN_MIDDLE = 2'd1;
	localparam logic [1:0] BTN_RIGHT  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HOOK_ENABLE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_PRESS   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_THR   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MIN   = 8'd3;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_SCROLL_THR = 16'd60;
	localparam logic [15:0] RST_SCROLL_MIN = 16'd25;

	typedef struct packed {
		logic [15:0] threshold;
		logic [15:0] min_interval;
	} scroll_cfg_t;

	typedef struct packed {
		logic fire;
		logic down;
	} scroll_res_t;

endpackage

/* design/mcdst_scroll.sv */
// Wheel accumulator and scroll rate limiter.
module mcdst_scroll (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wheel_go,
	input  logic signed [15:0]     wheel_step,
	input  logic [31:0]            time_ms,
	input  mcdst_pkg::scroll_cfg_t cfg,
	output mcdst_pkg::scroll_res_t res
);

	logic signed [31:0] acc_q;
	logic [31:0]        last_scroll_q;

	logic signed [32:0] sum_wide;
	logic signed [31:0] acc_next;
	logic [31:0]        mag;
	logic [31:0]        elapsed;

	always_comb begin
		sum_wide = 33'(acc_q) + 33'(wheel_step);
		// saturate to the signed 32-bit range
		if (sum_wide[32] != sum_wide[31]) begin
			acc_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			acc_next = sum_wide[31:0];
		end
		mag     = acc_next[31] ? (32'd0 - 32'(acc_next)) : 32'(acc_next);
		elapsed = time_ms - last_scroll_q;
		res.fire = (mag >= {16'd0, cfg.threshold}) && !elapsed[31]
			&& (elapsed >= {16'd0, cfg.min_interval});
		res.down = !(acc_next > 32'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			last_scroll_q <= '0;
		end else if (wheel_go) begin
			if (res.fire) begin
				acc_q         <= '0;
				last_scroll_q <= time_ms;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

/* design/mouse_click_debounce_scroll_throttle.sv */
// Top level of the mouse click debounce and scroll throttle block.
//
// Input channel: in_valid/in_stall with command, wheel_step, time_ms and
// pass_only. Output channel: out_valid/out_stall with event_code. Each input
// transaction gives zero or one output transaction.
// A result is registered and presented in the cycle after its input transaction.
// Throughput: one input transaction per cycle; all state (click times, wheel
// accumulator, last scroll time) updates at the accepting edge, so the next
// event sees it at once. The single output register sets the rate: a new
// input is taken whenever that register is empty or drained in the same cycle.
// When the receiver stalls a held result, in_stall rises and the block holds
// everything until the result is taken.
// Reset clears the output register, click times, accumulator and scroll
// time, and loads the configuration registers with enable=1, press=1,
// threshold=60 and minimum interval=25.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at the
// next edge; indexes beyond the register list are ignored.
module mouse_click_debounce_scroll_throttle #(
	parameter int unsigned DEBOUNCE_MS = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    command,
	input  logic signed [15:0]            wheel_step,
	input  logic [31:0]                   time_ms,
	input  logic                          pass_only,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_code,
	input  logic                          cfg_we,
	input  logic [mcdst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	logic                   hook_enable_q;
	logic                   trig_press_q;
	mcdst_pkg::scroll_cfg_t scroll_cfg_q;

	logic [31:0] last_click_q [3];
	logic        out_valid_q;
	logic [2:0]  event_code_q;

	logic                   in_acc;
	logic                   active;
	logic [1:0]             btn;
	logic [31:0]            btn_last;
	logic                   edge_match;
	logic                   click_fire;
	logic                   is_button;
	logic                   wheel_go;
	mcdst_pkg::scroll_res_t scroll_res;
	logic                   hit;
	logic [2:0]             hit_code;

	assign in_stall   = out_valid_q && out_stall;
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;

	assign active    = in_acc && !pass_only && hook_enable_q;
	assign is_button = (command < mcdst_pkg::CMD_WHEEL);
	assign wheel_go  = active && (command == mcdst_pkg::CMD_WHEEL);
	assign btn       = command[2:1];

	always_comb begin
		unique case (btn)
			mcdst_pkg::BTN_LEFT:   btn_last = last_click_q[0];
			mcdst_pkg::BTN_MIDDLE: btn_last = last_click_q[1];
			mcdst_pkg::BTN_RIGHT:  btn_last = last_click_q[2];
			default:               btn_last = '0;
		endcase
		// even commands are presses
		edge_match = trig_press_q ? !command[0] : command[0];
		click_fire = active && is_button && edge_match
			&& ((time_ms - btn_last) >= 32'(DEBOUNCE_MS));
	end

	mcdst_scroll u_scroll (
		.clk         (clk),
		.arst_n      (arst_n),
		.wheel_go    (wheel_go),
		.wheel_step  (wheel_step),
		.time_ms     (time_ms),
		.cfg         (scroll_cfg_q),
		.res         (scroll_res)
	);

	always_comb begin
		hit      = click_fire || (wheel_go && scroll_res.fire);
		hit_code = mcdst_pkg::EV_LEFT;
		if (click_fire) begin
			unique case (btn)
				mcdst_pkg::BTN_LEFT:   hit_code = mcdst_pkg::EV_LEFT;
				mcdst_pkg::BTN_MIDDLE: hit_code = mcdst_pkg::EV_MIDDLE;
				default:               hit_code = mcdst_pkg::EV_RIGHT;
			endcase
		end else if (scroll_res.down) begin
			hit_code = mcdst_pkg::EV_SCROLL_DOWN;
		end else begin
			hit_code = mcdst_pkg::EV_SCROLL_UP;
		end
	end

	// click times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_click_q[0] <= '0;
			last_click_q[1] <= '0;
			last_click_q[2] <= '0;
		end else if (click_fire) begin
			if (btn == mcdst_pkg::BTN_LEFT)   last_click_q[0] <= time_ms;
			if (btn == mcdst_pkg::BTN_MIDDLE) last_click_q[1] <= time_ms;
			if (btn == mcdst_pkg::BTN_RIGHT)  last_click_q[2] <= time_ms;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= hit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && hit) begin
			event_code_q <= hit_code;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hook_enable_q             <= 1'b1;
			trig_press_q              <= 1'b1;
			scroll_cfg_q.threshold    <= mcdst_pkg::RST_SCROLL_THR;
			scroll_cfg_q.min_interval <= mcdst_pkg::RST_SCROLL_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcdst_pkg::REG_HOOK_ENABLE: hook_enable_q             <= cfg_data[0];
				mcdst_pkg::REG_TRIG_PRESS:  trig_press_q              <= cfg_data[0];
				mcdst_pkg::REG_SCROLL_THR:  scroll_cfg_q.threshold    <= cfg_data;
				mcdst_pkg::REG_SCROLL_MIN:  scroll_cfg_q.min_interval <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* design/mcdst_checker.sv */
// Port-level checker for the mouse click debounce and scroll throttle block.
module mcdst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          pass_only,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    event_code
);

	// a held result stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code))
		else $error("output transaction changed while stalled");

	// input is only stalled behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held result");

	// a pass-only transaction never yields a result
	a_pass_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && pass_only |=> !out_valid)
		else $error("result after pass-only transaction");

	// a new result needs an input transaction in the cycle before
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid && out_stall) |-> $past(in_valid && !in_stall))
		else $error("result without input transaction");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= mcdst_pkg::EV_SCROLL_DOWN)
		else $error("event code out of range");

endmodule

bind mouse_click_debounce_scroll_throttle mcdst_checker u_mcdst_checker (.*);
